>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the LED pixel PWM encoder.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked concurrent check, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication check: when cond holds, prop must hold next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/lpe_pkg.sv
// Package for the LED pixel PWM encoder: state type, register indexes,
// constants and the brightness factor table. No dependencies.
package lpe_pkg;

    localparam int BITS_PER_PIXEL = 24;
    localparam int RESET_SLOTS_DEF = 50;
    localparam int CHAN_W = 8;
    localparam int CHANNELS = 3;
    localparam int FACTOR_W = 17;
    localparam int FRAC_W = 16;
    localparam int PROD_W = CHAN_W + FACTOR_W;

    localparam logic [5:0] MAX_ANGLE = 6'd45;
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'd65536;

    // Configuration register indexes
    localparam logic [1:0] CFG_EFFECT_ENABLE = 2'd0;
    localparam logic [1:0] CFG_BRIGHTNESS = 2'd1;
    localparam logic [1:0] CFG_ONE_DUTY = 2'd2;
    localparam logic [1:0] CFG_ZERO_DUTY = 2'd3;

    // Register reset values
    localparam logic [7:0] ONE_DUTY_RST = 8'd60;
    localparam logic [7:0] ZERO_DUTY_RST = 8'd30;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SEND,
        ST_FLUSH
    } state_t;

    // round(65536 * tan(angle degrees)), 0..45
    function automatic logic [FACTOR_W-1:0] tan_q16(input logic [5:0] angle);
        logic [FACTOR_W-1:0] f;
        unique case (angle)
            6'd0:  f = 17'd0;
            6'd1:  f = 17'd1144;
            6'd2:  f = 17'd2289;
            6'd3:  f = 17'd3435;
            6'd4:  f = 17'd4583;
            6'd5:  f = 17'd5734;
            6'd6:  f = 17'd6888;
            6'd7:  f = 17'd8047;
            6'd8:  f = 17'd9210;
            6'd9:  f = 17'd10380;
            6'd10: f = 17'd11556;
            6'd11: f = 17'd12739;
            6'd12: f = 17'd13930;
            6'd13: f = 17'd15130;
            6'd14: f = 17'd16340;
            6'd15: f = 17'd17560;
            6'd16: f = 17'd18792;
            6'd17: f = 17'd20036;
            6'd18: f = 17'd21294;
            6'd19: f = 17'd22566;
            6'd20: f = 17'd23853;
            6'd21: f = 17'd25157;
            6'd22: f = 17'd26478;
            6'd23: f = 17'd27818;
            6'd24: f = 17'd29179;
            6'd25: f = 17'd30560;
            6'd26: f = 17'd31964;
            6'd27: f = 17'd33392;
            6'd28: f = 17'd34846;
            6'd29: f = 17'd36327;
            6'd30: f = 17'd37837;
            6'd31: f = 17'd39378;
            6'd32: f = 17'd40951;
            6'd33: f = 17'd42560;
            6'd34: f = 17'd44205;
            6'd35: f = 17'd45889;
            6'd36: f = 17'd47615;
            6'd37: f = 17'd49385;
            6'd38: f = 17'd51202;
            6'd39: f = 17'd53070;
            6'd40: f = 17'd54991;
            6'd41: f = 17'd56970;
            6'd42: f = 17'd59009;
            6'd43: f = 17'd61113;
            6'd44: f = 17'd63287;
            default: f = FACTOR_ONE;
        endcase
        return f;
    endfunction

endpackage

>>> rtl/led_pixel_pwm_encoder.sv
// Top level of the LED pixel PWM encoder: brightness scaling, bit-serial
// PWM slot emission and end-of-frame reset slots. Uses lpe_pkg, assert_macros.svh.
//
//  Channel   | Dir | Signals                               | Content
//  ----------+-----+---------------------------------------+------------------------------
//  s_axis    | in  | tvalid tready tdata[23:0] tuser[0]    | pixel colours / end of frame
//  m_axis    | out | tvalid tready tdata[7:0] tlast        | one PWM compare value per slot
//  cfg       | in  | cfg_valid cfg_ready cfg_addr cfg_data | register writes, always ready
//
// A pixel is accepted when idle, scaled in the shared 8x17 multiplier (one
// colour channel per cycle), then sent as 24 slots shifted out of the colour
// register one bit per cycle while m_axis is not stalled. An end of frame sends
// RESET_SLOTS zero-duty slots. Reset is asynchronous; it clears the sequencer,
// the output valid and loads the register defaults. A stalled m_axis holds the slot
// in the output register and freezes the shift register; input is taken only when idle.

`include "assert_macros.svh"

module led_pixel_pwm_encoder #(
    parameter int RESET_SLOTS = lpe_pkg::RESET_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic        s_axis_tuser,   // action[0]: 1 = end of frame

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // duty[7:0]
    output logic        m_axis_tlast,   // last slot of the transaction's item

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_data
);

    localparam int MAX_SLOTS = (RESET_SLOTS > lpe_pkg::BITS_PER_PIXEL) ?
                               RESET_SLOTS : lpe_pkg::BITS_PER_PIXEL;
    localparam int CNT_W = $clog2(MAX_SLOTS);
    localparam int CW = lpe_pkg::CHAN_W;
    localparam int WORD_W = lpe_pkg::BITS_PER_PIXEL;

    // configuration registers
    logic                         effect_en_reg;
    logic [5:0]                   brightness_reg;
    logic [7:0]                   one_duty_reg;
    logic [7:0]                   zero_duty_reg;

    // sequencer and datapath
    lpe_pkg::state_t              state_reg, state_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [WORD_W-1:0]            sh_reg, sh_next;
    logic [lpe_pkg::FACTOR_W-1:0] factor_reg, factor_next;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_duty_reg, out_duty_next;
    logic                         out_last_reg, out_last_next;

    logic                         in_acc;
    logic                         out_free;
    logic [lpe_pkg::PROD_W-1:0]   prod;
    logic [CW-1:0]                scaled;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == lpe_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_duty_reg;
    assign m_axis_tlast  = out_last_reg;

    // one channel per cycle; factor <= 1.0 so the integer part fits 8 bits
    assign prod   = lpe_pkg::PROD_W'(sh_reg[WORD_W-1 -: CW]) *
                    lpe_pkg::PROD_W'(factor_reg);
    assign scaled = prod[lpe_pkg::FRAC_W +: CW];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_en_reg  <= 1'b1;
            brightness_reg <= '0;
            one_duty_reg   <= lpe_pkg::ONE_DUTY_RST;
            zero_duty_reg  <= lpe_pkg::ZERO_DUTY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                lpe_pkg::CFG_EFFECT_ENABLE: effect_en_reg <= cfg_data[0];
                lpe_pkg::CFG_BRIGHTNESS:
                    brightness_reg <= (cfg_data[5:0] > lpe_pkg::MAX_ANGLE) ?
                                      lpe_pkg::MAX_ANGLE : cfg_data[5:0];
                lpe_pkg::CFG_ONE_DUTY:  one_duty_reg  <= cfg_data;
                lpe_pkg::CFG_ZERO_DUTY: zero_duty_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpe_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        sh_reg       <= sh_next;
        factor_reg   <= factor_next;
        out_duty_reg <= out_duty_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sh_next        = sh_reg;
        factor_next    = factor_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_duty_next  = out_duty_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            lpe_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_axis_tuser)
                    begin
                        cnt_next   = CNT_W'(RESET_SLOTS - 1);
                        state_next = lpe_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        // green in the top byte so it leaves first
                        sh_next     = {s_axis_tdata[15:8], s_axis_tdata[7:0],
                                       s_axis_tdata[23:16]};
                        factor_next = effect_en_reg ? lpe_pkg::tan_q16(brightness_reg)
                                                    : lpe_pkg::FACTOR_ONE;
                        cnt_next    = CNT_W'(lpe_pkg::CHANNELS - 1);
                        state_next  = lpe_pkg::ST_SCALE;
                    end
                end
            end

            lpe_pkg::ST_SCALE:
            begin
                // rotate by one channel, replacing it with its scaled value
                sh_next = {sh_reg[WORD_W-CW-1:0], scaled};
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(WORD_W - 1);
                    state_next = lpe_pkg::ST_SEND;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            lpe_pkg::ST_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_duty_next  = sh_reg[WORD_W-1] ? one_duty_reg : zero_duty_reg;
                    out_last_next  = (cnt_reg == '0);
                    sh_next        = {sh_reg[WORD_W-2:0], 1'b0};
                    if (cnt_reg == '0)
                        state_next = lpe_pkg::ST_IDLE;
                    else
                        cnt_next = cnt_reg - 1'b1;
                end
            end

            lpe_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_duty_next  = '0;
                    out_last_next  = (cnt_reg == '0);
                    if (cnt_reg == '0)
                        state_next = lpe_pkg::ST_IDLE;
                    else
                        cnt_next = cnt_reg - 1'b1;
                end
            end

            default: state_next = lpe_pkg::ST_IDLE;
        endcase
    end

    `ASSERT_CLK(a_bright_range, (brightness_reg <= lpe_pkg::MAX_ANGLE), "brightness above 45")
    `ASSERT_NEXT(a_pixel_scales, (in_acc && !s_axis_tuser),
        (state_reg == lpe_pkg::ST_SCALE), "pixel did not enter scaling")
    `ASSERT_NEXT(a_last_to_idle,
        ((state_reg == lpe_pkg::ST_SEND || state_reg == lpe_pkg::ST_FLUSH) &&
         out_free && cnt_reg == '0),
        (state_reg == lpe_pkg::ST_IDLE && out_valid_reg && out_last_reg),
        "final slot not flagged or sequencer not idle")
    `ASSERT_CLK(a_factor_range,
        (state_reg != lpe_pkg::ST_SCALE || factor_reg <= lpe_pkg::FACTOR_ONE),
        "scale factor above one")

endmodule

>>> tb/led_pixel_pwm_encoder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for led_pixel_pwm_encoder: directed and random pixel and
// end-of-frame streams, checked slot by slot against a local predictor.
// Depends on lpe_pkg and the RTL top level only.

module led_pixel_pwm_encoder_tb;

    localparam int EOF_SLOTS = lpe_pkg::RESET_SLOTS_DEF;
    localparam int PIXEL_SLOTS = lpe_pkg::BITS_PER_PIXEL;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;

    // Brightness gain per angle: round(65536 * tan(deg)), deg = 0..45
    localparam int unsigned TAN_GAIN [46] = '{
            0,  1144,  2289,  3435,  4583,  5734,  6888,  8047,
         9210, 10380, 11556, 12739, 13930, 15130, 16340, 17560,
        18792, 20036, 21294, 22566, 23853, 25157, 26478, 27818,
        29179, 30560, 31964, 33392, 34846, 36327, 37837, 39378,
        40951, 42560, 44205, 45889, 47615, 49385, 51202, 53070,
        54991, 56970, 59009, 61113, 63287, 65536
    };

    // One expected PWM slot
    typedef struct packed {
        logic [7:0] duty;
        logic       last;
    } slot_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // red[7:0], green[15:8], blue[23:16]
    logic        s_axis_tuser = 1'b0;   // action[0]: 1 = end of frame

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // duty[7:0]
    logic        m_axis_tlast;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_addr = '0;
    logic [7:0]  cfg_data = '0;

    // Shadow copy of the register file, updated on each cfg transaction
    logic        fx_enable = 1'b1;
    logic [5:0]  fx_angle = '0;
    logic [7:0]  duty_one = lpe_pkg::ONE_DUTY_RST;
    logic [7:0]  duty_zero = lpe_pkg::ZERO_DUTY_RST;

    slot_t slots_due[$];        // expected slots, oldest first
    int    err_count = 0;
    int    cycle_count = 0;
    int    send_idle_pct = 0;   // chance per cycle that the pixel source holds off
    int    recv_idle_pct = 0;   // chance per cycle that the slot sink stalls

    led_pixel_pwm_encoder #(
        .RESET_SLOTS(EOF_SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Slot sink backpressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // floor(v * gain / 65536); the product never exceeds 24 bits
    function automatic logic [7:0] dim_channel(logic [7:0] v);
        int unsigned prod;
        prod = v * TAN_GAIN[fx_angle];
        return prod[23:16];
    endfunction

    // Queue the slots that one accepted input transaction must produce
    function automatic void expect_slots(logic eof, logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b);
        logic [7:0]  rr;
        logic [7:0]  gg;
        logic [7:0]  bb;
        logic [23:0] grb;
        slot_t       s;
        if (eof)
        begin
            // colors ignored: a run of zero-duty reset slots
            for (int k = 0; k < EOF_SLOTS; k++)
            begin
                s.duty = '0;
                s.last = (k == EOF_SLOTS - 1);
                slots_due.push_back(s);
            end
        end
        else
        begin
            rr = fx_enable ? dim_channel(r) : r;
            gg = fx_enable ? dim_channel(g) : g;
            bb = fx_enable ? dim_channel(b) : b;
            // wire order is green, red, blue, MSB first
            grb = {gg, rr, bb};
            for (int k = 0; k < PIXEL_SLOTS; k++)
            begin
                s.duty = grb[PIXEL_SLOTS - 1 - k] ? duty_one : duty_zero;
                s.last = (k == PIXEL_SLOTS - 1);
                slots_due.push_back(s);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Slot checker: every m_axis transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin : check_slot
            slot_t want;
            if (slots_due.size() == 0)
            begin
                $error("unexpected slot: duty %0d last %0b", m_axis_tdata, m_axis_tlast);
                err_count++;
            end
            else
            begin
                want = slots_due.pop_front();
                if (m_axis_tdata !== want.duty)
                begin
                    $error("duty: expected %0d, got %0d", want.duty, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One input transaction. tvalid stays high afterwards so back-to-back
    // items never drop it; the next call or drain_slots lowers it.
    task automatic send_item(logic eof, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        s_axis_tuser  <= eof;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expect_slots(eof, r, g, b);
    endtask

    // One register write; cfg_valid is left high for back-to-back writes
    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            lpe_pkg::CFG_EFFECT_ENABLE: fx_enable = data[0];
            lpe_pkg::CFG_BRIGHTNESS:
                fx_angle = (data[5:0] > lpe_pkg::MAX_ANGLE) ? lpe_pkg::MAX_ANGLE
                                                             : data[5:0];
            lpe_pkg::CFG_ONE_DUTY:      duty_one = data;
            lpe_pkg::CFG_ZERO_DUTY:     duty_zero = data;
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic en, logic [7:0] angle, logic [7:0] one, logic [7:0] zero);
        write_reg(lpe_pkg::CFG_EFFECT_ENABLE, {7'd0, en});
        write_reg(lpe_pkg::CFG_BRIGHTNESS, angle);
        write_reg(lpe_pkg::CFG_ONE_DUTY, one);
        write_reg(lpe_pkg::CFG_ZERO_DUTY, zero);
        cfg_release();
    endtask

    // Stop sending, let every expected slot arrive and the block fall idle
    task automatic drain_slots();
        s_axis_tvalid <= 1'b0;
        while (slots_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Color byte biased toward the extremes
    function automatic logic [7:0] rand_color();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] rand_duty();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: scaling on at 0 degrees blanks every color to zero_duty
    task automatic test_reset_defaults();
        send_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
        send_item(1'b0, 8'h00, 8'h00, 8'h00);
        drain_slots();
    endtask

    // Raw colors: channel order and bit order, extreme duties both ways round
    task automatic test_raw_color();
        set_regs(1'b0, 8'd0, 8'hFF, 8'h00);
        send_item(1'b0, 8'hFF, 8'h00, 8'h00);
        send_item(1'b0, 8'h00, 8'hFF, 8'h00);
        send_item(1'b0, 8'h00, 8'h00, 8'hFF);
        send_item(1'b0, 8'hA5, 8'h3C, 8'h81);
        drain_slots();
        set_regs(1'b0, 8'd0, 8'h00, 8'hFF);
        send_item(1'b0, 8'h0F, 8'hF0, 8'h55);
        drain_slots();
    endtask

    // Brightness scaling at 45, 1, 44 and 30 degrees; 45 degrees passes colors through unchanged
    task automatic test_scaling();
        set_regs(1'b1, 8'd45, 8'hAA, 8'h55);
        send_item(1'b0, 8'hFF, 8'h01, 8'h80);
        drain_slots();
        write_reg(lpe_pkg::CFG_BRIGHTNESS, 8'd1);
        cfg_release();
        send_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
        drain_slots();
        write_reg(lpe_pkg::CFG_BRIGHTNESS, 8'd44);
        cfg_release();
        send_item(1'b0, 8'hFF, 8'h7F, 8'h01);
        drain_slots();
        write_reg(lpe_pkg::CFG_BRIGHTNESS, 8'd30);
        cfg_release();
        send_item(1'b0, 8'hC8, 8'h64, 8'h33);
        drain_slots();
    endtask

    // Out-of-range brightness writes are stored as 45 degrees
    task automatic test_angle_clamp();
        write_reg(lpe_pkg::CFG_BRIGHTNESS, 8'd46);
        cfg_release();
        send_item(1'b0, 8'hFE, 8'h9A, 8'h21);
        drain_slots();
        write_reg(lpe_pkg::CFG_BRIGHTNESS, 8'd63);
        cfg_release();
        send_item(1'b0, 8'h12, 8'hED, 8'h77);
        drain_slots();
        write_reg(lpe_pkg::CFG_BRIGHTNESS, 8'hFF);
        cfg_release();
        send_item(1'b0, 8'h5A, 8'hC3, 8'hFF);
        drain_slots();
    endtask

    // End of frame ignores its color fields; back-to-back frames too
    task automatic test_end_of_frame();
        send_item(1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_item(1'b1, 8'h00, 8'h00, 8'h00);
        send_item(1'b0, 8'h80, 8'h40, 8'h20);
        send_item(1'b1, 8'h6B, 8'h2E, 8'hD9);
        drain_slots();
    endtask

    // Random frames under one idling pattern, with a register change midway.
    // Mostly pixel runs closed by an end of frame; some runs left open and
    // some stray ends of frame.
    task automatic test_random_frames(int items, int s_idle, int r_idle);
        int    sent;
        int    npix;
        logic  en;
        logic [7:0] angle;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int half = 0; half < 2; half++)
        begin
            drain_slots();
            en = ($urandom_range(3) != 0);
            case ($urandom_range(3))
                0:       angle = 8'd0;
                1:       angle = 8'd45;
                default: angle = 8'($urandom_range(255));
            endcase
            set_regs(en, angle, rand_duty(), rand_duty());
            sent = 0;
            while (sent < items / 2)
            begin
                if ($urandom_range(9) == 0)
                begin
                    send_item(1'b1, rand_color(), rand_color(), rand_color());
                    sent++;
                end
                else
                begin
                    npix = $urandom_range(1, 8);
                    for (int p = 0; p < npix; p++)
                        send_item(1'b0, rand_color(), rand_color(), rand_color());
                    sent += npix;
                    if ($urandom_range(7) != 0)
                    begin
                        send_item(1'b1, rand_color(), rand_color(), rand_color());
                        sent++;
                    end
                end
            end
        end
        drain_slots();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 15;
        recv_idle_pct = 47;
        test_reset_defaults();
        test_raw_color();
        test_scaling();
        test_angle_clamp();
        test_end_of_frame();

        test_random_frames(100, 15, 47);
        test_random_frames(100, 47, 15);
        test_random_frames(100, 0, 0);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/lpe_pkg.sv
rtl/led_pixel_pwm_encoder.sv
tb/led_pixel_pwm_encoder_tb.sv
